[rtl/divisor_sum_sigma_macros.svh]
// Assertion macros shared by the divisor sum block.
`ifndef DIVISOR_SUM_SIGMA_MACROS_SVH
`define DIVISOR_SUM_SIGMA_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dss_pkg.sv]
// Types, constants and the control program of the divisor sum sequencer.
package dss_pkg;

    localparam int WIDTH   = 32;
    localparam int TDATA_W = ((WIDTH + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(WIDTH);
    localparam int PC_W    = 5;

    typedef logic [WIDTH-1:0] t_word;
    typedef logic [PC_W-1:0]  t_pc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT_GS,
        OP_HALVE,
        OP_MUL_GS,
        OP_SET_P3,
        OP_DIV,
        OP_STEP_PW,
        OP_ADD_GS,
        OP_P_ADD2,
        OP_MUL_REM1,
        OP_CLR_ACC,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_REM_ZERO,
        C_REM_ONE,
        C_REM_ODD,
        C_NEXT_EVEN,
        C_P_GT_Q,
        C_R_NZ,
        C_R_Z,
        C_REM_LE1
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Step addresses of the control program.
    localparam t_pc S_WAIT     = 5'd0;
    localparam t_pc S_CHK_ZERO = 5'd1;
    localparam t_pc S_CHK_ONE  = 5'd2;
    localparam t_pc S_TWO_INIT = 5'd3;
    localparam t_pc S_HALVE    = 5'd4;
    localparam t_pc S_TWO_MUL  = 5'd5;
    localparam t_pc S_ODD      = 5'd6;
    localparam t_pc S_CAND     = 5'd7;
    localparam t_pc S_CHK_P    = 5'd8;
    localparam t_pc S_CHK_R    = 5'd9;
    localparam t_pc S_PSTEP    = 5'd10;
    localparam t_pc S_PADD     = 5'd11;
    localparam t_pc S_PDIV     = 5'd12;
    localparam t_pc S_PCHK     = 5'd13;
    localparam t_pc S_PMUL     = 5'd14;
    localparam t_pc S_NEXT     = 5'd15;
    localparam t_pc S_TAIL     = 5'd16;
    localparam t_pc S_TAIL_MUL = 5'd17;
    localparam t_pc S_EMIT     = 5'd18;
    localparam t_pc S_ZERO     = 5'd19;

    // Jump to target when the condition holds, else fall through.
    function automatic t_uword ucode(input t_pc pc);
        t_uword uw;
        case (pc)
            S_WAIT:     uw = '{OP_LOAD,     C_NO_IN,     S_WAIT};
            S_CHK_ZERO: uw = '{OP_NOP,      C_REM_ZERO,  S_ZERO};
            S_CHK_ONE:  uw = '{OP_NOP,      C_REM_ONE,   S_EMIT};
            S_TWO_INIT: uw = '{OP_INIT_GS,  C_REM_ODD,   S_ODD};
            S_HALVE:    uw = '{OP_HALVE,    C_NEXT_EVEN, S_HALVE};
            S_TWO_MUL:  uw = '{OP_MUL_GS,   C_NEVER,     S_WAIT};
            S_ODD:      uw = '{OP_SET_P3,   C_NEVER,     S_WAIT};
            S_CAND:     uw = '{OP_DIV,      C_NEVER,     S_WAIT};
            S_CHK_P:    uw = '{OP_NOP,      C_P_GT_Q,    S_TAIL};
            S_CHK_R:    uw = '{OP_INIT_GS,  C_R_NZ,      S_NEXT};
            S_PSTEP:    uw = '{OP_STEP_PW,  C_NEVER,     S_WAIT};
            S_PADD:     uw = '{OP_ADD_GS,   C_NEVER,     S_WAIT};
            S_PDIV:     uw = '{OP_DIV,      C_NEVER,     S_WAIT};
            S_PCHK:     uw = '{OP_NOP,      C_R_Z,       S_PSTEP};
            S_PMUL:     uw = '{OP_MUL_GS,   C_NEVER,     S_WAIT};
            S_NEXT:     uw = '{OP_P_ADD2,   C_ALWAYS,    S_CAND};
            S_TAIL:     uw = '{OP_NOP,      C_REM_LE1,   S_EMIT};
            S_TAIL_MUL: uw = '{OP_MUL_REM1, C_NEVER,     S_WAIT};
            S_EMIT:     uw = '{OP_EMIT,     C_ALWAYS,    S_WAIT};
            S_ZERO:     uw = '{OP_CLR_ACC,  C_ALWAYS,    S_EMIT};
            default:    uw = '{OP_NOP,      C_ALWAYS,    S_WAIT};
        endcase
        return uw;
    endfunction

endpackage

[rtl/divisor_sum_sigma.sv]
// Divisor sum sigma(n) by trial division, run by a microcoded sequencer.
//
// Takes one number n on the input stream and returns sigma(n), the sum of
// its positive divisors modulo 2^32, as one item on the output stream. One
// item is worked on at a time; a new n is taken only when the sequencer is
// back at its wait step, while a finished result may still sit in the
// output register. The time per item is set by the bit-serial divider that
// the program shares for every trial: each odd candidate takes one
// division, each factor found takes another, and each distinct prime
// adds one multiply to fold its sum into the product. Factors of two are
// stripped by a halving step that needs no division. Zero and one skip
// the trials; the worst case, a prime near 2^32, tries about 32768 odd
// candidates.
`include "divisor_sum_sigma_macros.svh"

module divisor_sum_sigma (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [dss_pkg::TDATA_W-1:0]  s_axis_tdata,   // [31:0] n
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [dss_pkg::TDATA_W-1:0]  m_axis_tdata    // [31:0] sigma
);

    localparam int W = dss_pkg::WIDTH;

    dss_pkg::t_pc    r_pc, n_pc;
    dss_pkg::t_uword w_uw;
    dss_pkg::t_word  r_rem, n_rem;
    dss_pkg::t_word  r_p, n_p;
    dss_pkg::t_word  r_pw, n_pw;
    dss_pkg::t_word  r_gs, n_gs;
    dss_pkg::t_word  r_acc, n_acc;
    dss_pkg::t_word  r_q, n_q;
    dss_pkg::t_word  r_r, n_r;
    dss_pkg::t_word  r_dq, n_dq;
    dss_pkg::t_word  r_dr, n_dr;
    logic [dss_pkg::CNT_W-1:0] r_dcnt, n_dcnt;
    logic            r_div_busy, n_div_busy;
    logic            r_out_valid, n_out_valid;
    dss_pkg::t_word  r_out_sigma, n_out_sigma;

    logic            w_cond;
    logic            w_go;
    logic            w_last;
    logic [W:0]      w_part;
    logic [W:0]      w_diff;
    logic            w_fit;
    dss_pkg::t_word  w_dr_new;
    dss_pkg::t_word  w_dq_new;
    dss_pkg::t_word  w_mul_a;
    dss_pkg::t_word  w_mul_b;
    dss_pkg::t_word  w_prod;

    assign w_uw          = dss_pkg::ucode(r_pc);
    assign s_axis_tready = (r_pc == dss_pkg::S_WAIT);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = dss_pkg::TDATA_W'(r_out_sigma);

    // One restoring divider step per cycle: remainder first, quotient bits shift in.
    assign w_last   = r_div_busy && (r_dcnt == '0);
    assign w_part   = {r_dr, r_dq[W-1]};
    assign w_diff   = w_part - {1'b0, r_p};
    assign w_fit    = !w_diff[W];
    assign w_dr_new = w_fit ? w_diff[W-1:0] : w_part[W-1:0];
    assign w_dq_new = {r_dq[W-2:0], w_fit};

    // Shared multiplier, low word kept.
    always_comb begin
        case (w_uw.op)
            dss_pkg::OP_STEP_PW: begin
                w_mul_a = r_pw;
                w_mul_b = r_p;
            end
            dss_pkg::OP_MUL_REM1: begin
                w_mul_a = r_acc;
                w_mul_b = r_rem + dss_pkg::t_word'(1);
            end
            default: begin
                w_mul_a = r_acc;
                w_mul_b = r_gs;
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        case (w_uw.cond)
            dss_pkg::C_NEVER:     w_cond = 1'b0;
            dss_pkg::C_ALWAYS:    w_cond = 1'b1;
            dss_pkg::C_NO_IN:     w_cond = !s_axis_tvalid;
            dss_pkg::C_REM_ZERO:  w_cond = (r_rem == '0);
            dss_pkg::C_REM_ONE:   w_cond = (r_rem == dss_pkg::t_word'(1));
            dss_pkg::C_REM_ODD:   w_cond = r_rem[0];
            dss_pkg::C_NEXT_EVEN: w_cond = !r_rem[1];
            dss_pkg::C_P_GT_Q:    w_cond = (r_p > r_q);
            dss_pkg::C_R_NZ:      w_cond = (r_r != '0);
            dss_pkg::C_R_Z:       w_cond = (r_r == '0);
            dss_pkg::C_REM_LE1:   w_cond = (r_rem <= dss_pkg::t_word'(1));
            default:              w_cond = 1'b0;
        endcase
    end

    always_comb begin
        case (w_uw.op)
            dss_pkg::OP_DIV:  w_go = w_last;
            dss_pkg::OP_EMIT: w_go = !r_out_valid || m_axis_tready;
            default:          w_go = 1'b1;
        endcase
    end

    always_comb begin
        n_pc        = r_pc;
        n_rem       = r_rem;
        n_p         = r_p;
        n_pw        = r_pw;
        n_gs        = r_gs;
        n_acc       = r_acc;
        n_q         = r_q;
        n_r         = r_r;
        n_dq        = r_dq;
        n_dr        = r_dr;
        n_dcnt      = r_dcnt;
        n_div_busy  = r_div_busy;
        n_out_valid = r_out_valid;
        n_out_sigma = r_out_sigma;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_go) begin
            n_pc = w_cond ? w_uw.target : r_pc + dss_pkg::t_pc'(1);
        end

        case (w_uw.op)
            dss_pkg::OP_LOAD: begin
                n_rem = s_axis_tdata[W-1:0];
                n_acc = dss_pkg::t_word'(1);
            end
            dss_pkg::OP_INIT_GS: begin
                n_pw = dss_pkg::t_word'(1);
                n_gs = dss_pkg::t_word'(1);
            end
            dss_pkg::OP_HALVE: begin
                n_rem = r_rem >> 1;
                n_pw  = r_pw << 1;
                n_gs  = r_gs + (r_pw << 1);
            end
            dss_pkg::OP_MUL_GS,
            dss_pkg::OP_MUL_REM1: begin
                n_acc = w_prod;
            end
            dss_pkg::OP_SET_P3: begin
                n_p = dss_pkg::t_word'(3);
            end
            dss_pkg::OP_DIV: begin
                if (!r_div_busy) begin
                    n_dq       = r_rem;
                    n_dr       = '0;
                    n_dcnt     = dss_pkg::CNT_W'(W - 1);
                    n_div_busy = 1'b1;
                end else begin
                    n_dq   = w_dq_new;
                    n_dr   = w_dr_new;
                    n_dcnt = r_dcnt - dss_pkg::CNT_W'(1);
                    if (w_last) begin
                        n_div_busy = 1'b0;
                        n_q        = w_dq_new;
                        n_r        = w_dr_new;
                    end
                end
            end
            dss_pkg::OP_STEP_PW: begin
                n_rem = r_q;
                n_pw  = w_prod;
            end
            dss_pkg::OP_ADD_GS: begin
                n_gs = r_gs + r_pw;
            end
            dss_pkg::OP_P_ADD2: begin
                n_p = r_p + dss_pkg::t_word'(2);
            end
            dss_pkg::OP_CLR_ACC: begin
                n_acc = '0;
            end
            dss_pkg::OP_EMIT: begin
                if (w_go) begin
                    n_out_valid = 1'b1;
                    n_out_sigma = r_acc;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= dss_pkg::S_WAIT;
            r_div_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_div_busy  <= n_div_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_p         <= n_p;
        r_pw        <= n_pw;
        r_gs        <= n_gs;
        r_acc       <= n_acc;
        r_q         <= n_q;
        r_r         <= n_r;
        r_dq        <= n_dq;
        r_dr        <= n_dr;
        r_dcnt      <= n_dcnt;
        r_out_sigma <= n_out_sigma;
    end

    `DSS_ASSERT_IMPL(a_div_in_div_step, i_clk, i_rst_n,
        r_div_busy, w_uw.op == dss_pkg::OP_DIV,
        "divider busy outside a divide step")
    `DSS_ASSERT_NEXT(a_rem_below_p, i_clk, i_rst_n,
        w_last, r_r < r_p,
        "remainder not below divisor")
    `DSS_ASSERT_IMPL(a_p_odd, i_clk, i_rst_n,
        r_pc == dss_pkg::S_CAND || r_pc == dss_pkg::S_CHK_P || r_pc == dss_pkg::S_NEXT,
        r_p[0] && (r_p > dss_pkg::t_word'(1)),
        "candidate not odd")
    `DSS_ASSERT_NEXT(a_emit_done, i_clk, i_rst_n,
        w_uw.op == dss_pkg::OP_EMIT && w_go,
        r_out_valid && r_pc == dss_pkg::S_WAIT,
        "result not posted")

endmodule

[tb/divisor_sum_checker.sv]
// Stream monitor and sigma(n) predictor for the divisor sum block.
`timescale 1ns / 100ps

module divisor_sum_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [dss_pkg::TDATA_W-1:0] i_in_data,    // [31:0] n
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [dss_pkg::TDATA_W-1:0] i_out_data,   // [31:0] sigma
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    typedef struct packed {
        dss_pkg::t_word n;
        dss_pkg::t_word sigma;
    } t_sum_entry;

    t_sum_entry sum_q[$];
    int         fails   = 0;
    int         checked = 0;

    // Sum of divisors by trial division; every product wraps at the word width.
    function automatic dss_pkg::t_word sigma_of(input dss_pkg::t_word n);
        dss_pkg::t_word rem;
        dss_pkg::t_word p;
        dss_pkg::t_word pw;
        dss_pkg::t_word gs;
        dss_pkg::t_word prod;
        if (n == '0)
            return '0;
        if (n == 1)
            return 1;
        prod = 1;
        rem  = n;
        if (!rem[0]) begin
            pw = 1;
            gs = 1;
            while (!rem[0]) begin
                rem = rem >> 1;
                pw  = pw << 1;
                gs  = gs + pw;
            end
            prod = prod * gs;
        end
        for (p = 3; p <= rem / p; p = p + 2) begin
            if (rem % p == 0) begin
                pw = 1;
                gs = 1;
                while (rem % p == 0) begin
                    rem = rem / p;
                    pw  = pw * p;
                    gs  = gs + pw;
                end
                prod = prod * gs;
            end
        end
        // leftover cofactor is a prime
        if (rem > 1)
            prod = prod * dss_pkg::t_word'(rem + 1);
        return prod;
    endfunction

    always @(posedge i_clk) begin : watch_b
        t_sum_entry     want;
        dss_pkg::t_word got;
        if (i_rst_n) begin
            // check the result before queuing a new item taken in the same cycle
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[dss_pkg::WIDTH-1:0];
                if (sum_q.size() == 0) begin
                    $display("%0t: sigma %0d arrived with no item outstanding", $time, got);
                    fails++;
                end else begin
                    want = sum_q.pop_front();
                    if (got !== want.sigma) begin
                        $display("%0t: sigma(%0d) expected %0d, actual %0d",
                                 $time, want.n, want.sigma, got);
                        fails++;
                    end
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                want.n     = i_in_data[dss_pkg::WIDTH-1:0];
                want.sigma = sigma_of(want.n);
                sum_q.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= sum_q.size();
        o_checked    <= checked;
    end

endmodule

[tb/tb_top.sv]
// Stimulus, stall control and verdict for the divisor sum block.
`timescale 1ns / 100ps

module tb_top;

    localparam int QUIET_LIMIT = 100000;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [dss_pkg::TDATA_W-1:0] s_axis_tdata  = '0;   // [31:0] n
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [dss_pkg::TDATA_W-1:0] m_axis_tdata;         // [31:0] sigma

    bit idle_on     = 1'b1;
    int quiet_count = 0;
    int fail_count;
    int pending;
    int checked;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    divisor_sum_sigma i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    divisor_sum_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Product of random small primes, kept inside 32 bits.
    function automatic dss_pkg::t_word smooth_number(input int terms);
        logic [63:0]    acc;
        dss_pkg::t_word f;
        acc = 1;
        for (int i = 0; i < terms; i++) begin
            case ($urandom_range(0, 11))
                0:       f = 2;
                1:       f = 3;
                2:       f = 5;
                3:       f = 7;
                4:       f = 11;
                5:       f = 13;
                6:       f = 17;
                7:       f = 19;
                8:       f = 23;
                9:       f = 29;
                10:      f = 31;
                default: f = 97;
            endcase
            if (acc * f <= 64'hFFFF_FFFF)
                acc = acc * f;
        end
        return acc[31:0];
    endfunction

    // Offer one item and hold it until taken; valid stays high afterward.
    task automatic send_n(input dss_pkg::t_word n);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= n;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Receiver: random stall bursts until the quiet tail of the run.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // End the run if no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stim_b
        dss_pkg::t_word n;
        dss_pkg::t_word q;
        logic [63:0]    wide;
        int             k;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners, prime powers, wrapping sums and dense bit patterns
        send_n(32'd0);
        send_n(32'd1);
        send_n(32'd2);
        send_n(32'd3);
        send_n(32'd4);
        send_n(32'd12);
        send_n(32'd496);
        send_n(32'd8128);
        send_n(32'd63001);           // 251 squared
        send_n(32'd65521);
        send_n(32'd65537);
        send_n(32'd1048573);         // prime just under 2^20
        send_n(32'h8000_0000);
        send_n(32'hFFFF_FFFF);
        send_n(32'hFFFF_0000);
        send_n(32'h5555_5555);
        send_n(32'hAAAA_AAAA);
        send_n(32'd3486784401);      // 3^20, geometric sum wraps
        send_n(32'd1220703125);      // 5^13
        send_n(32'd1977326743);      // 7^11
        send_n(32'd3234846615);      // odd primes 3..29, product wraps
        drain_results();

        for (int i = 0; i < 80; i++) begin
            if (i == 60)
                idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0: n = $urandom_range(0, 15);
                1, 2, 3: begin
                    // short random value moved anywhere in the word
                    k = $urandom_range(1, 18);
                    n = ($urandom & ((32'd1 << k) - 1)) << $urandom_range(0, 32 - k);
                end
                4, 5, 6, 7: n = smooth_number($urandom_range(1, 14));
                default: begin
                    q    = $urandom_range(3, 65535) | 32'd1;
                    wide = 64'(q) * smooth_number($urandom_range(0, 8));
                    n    = (wide <= 64'hFFFF_FFFF) ? wide[31:0] : q;
                end
            endcase
            send_n(n);
        end
        drain_results();
        repeat (16) @(posedge i_clk);

        $display("Covered %0d divisor sums: zero, one, primes, prime powers,", checked);
        $display("smooth and wrapping products, with stalls and a full drain pause.");
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
